// File: rtl/visible_bitmap_rank_select_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the visible bitmap rank/select block
// Immediate-cycle and next-cycle implication checks on clk, gated by rst_n.
// ----------------------------------------------------------------------------
`ifndef VISIBLE_BITMAP_RANK_SELECT_TOP_MACROS_SVH
`define VISIBLE_BITMAP_RANK_SELECT_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define VBRS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define VBRS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define VBRS_ASSERT_IMP(lbl, ante, cons, msg)
`define VBRS_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// File: rtl/vbrs_pkg.sv
// ----------------------------------------------------------------------------
// vbrs_pkg
// Shared widths, action codes and the word evaluation status type.
// ----------------------------------------------------------------------------
`default_nettype none

package vbrs_pkg;

  localparam int WORD_BITS = 32;
  localparam int WORD_LSB  = 5;
  localparam int ONES_W    = 6;
  localparam int PW        = 12;
  localparam int CW        = 11;

  localparam logic [CW-1:0] COUNTER_MAX = 11'd2047;

  localparam logic [2:0] ACT_MARK   = 3'd0;
  localparam logic [2:0] ACT_NEXT   = 3'd1;
  localparam logic [2:0] ACT_PREV   = 3'd2;
  localparam logic [2:0] ACT_RANK   = 3'd3;
  localparam logic [2:0] ACT_SELECT = 3'd4;
  localparam logic [2:0] ACT_CLEAR  = 3'd5;

  typedef struct packed {
    logic [WORD_BITS-1:0] masked;
    logic [ONES_W-1:0]    ones;
    logic [WORD_LSB-1:0]  lo_bit;
    logic [WORD_LSB-1:0]  hi_bit;
    logic                 any;
  } wstat_t;

endpackage

`default_nettype wire

// File: rtl/visible_bitmap_rank_select_top.sv
// ----------------------------------------------------------------------------
// visible_bitmap_rank_select_top
// Flow: trivial items go from acceptance through start and emit to the output
//   register, in-range marks also through eval; scans read one bitmap word per
//   eval step, up to ceil(count/32) words, and select then clears set bits of
//   the target word one by one to find it. One item at a time: the next word is
//   taken the cycle after the result loads, so the input waits while an item is
//   in flight, longer while the output stalls. One bitmap row a cycle, set by
//   the single read port of the bitmap memory. Reset: synchronous; control cleared
//   at once, then a pass over ceil(MAX/32) words zeroes it, no input taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

`include "visible_bitmap_rank_select_top_macros.svh"

module visible_bitmap_rank_select_top
  import vbrs_pkg::*;
#(
  parameter int MAX_ENTRIES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data,  // entries_in_use

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,     // [11:0] position, [12] matched, [13] narrow_only, zero
  input  logic [2:0]  in_tuser,     // [2:0] action
  input  logic        in_tlast,     // last_of_pass

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata     // [11:0] answer, [12] entry_visible, [23:13] selected_total
);

  localparam int NW   = (MAX_ENTRIES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW   = (NW > 1) ? $clog2(NW) : 1;
  localparam int MAXC = (MAX_ENTRIES > 2047) ? 2047 : MAX_ENTRIES;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_START = 6'b000100,
    S_EVAL  = 6'b001000,
    S_BITS  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  // control
  state_t         state_r, state_nxt;
  logic [CW-1:0]  cfg_r;
  logic [CW-1:0]  pc_r, pc_nxt;
  logic [CW-1:0]  total_r, total_nxt;
  logic [AW-1:0]  clr_addr_r;
  logic           out_valid_r, out_valid_nxt;

  // payload
  logic [2:0]     act_r;
  logic [PW-1:0]  pos_r;
  logic           matched_r, narrow_r, last_r;
  logic [PW-1:0]  lo_r, lo_nxt, hi_r, hi_nxt;
  logic [AW-1:0]  eval_addr_r, eval_addr_nxt;
  logic [PW-1:0]  cnt_r, cnt_nxt;
  logic [PW-1:0]  ans_r, ans_nxt;
  logic           vis_r, vis_nxt;
  logic [WORD_BITS-1:0] word_r, word_nxt;
  logic [ONES_W-1:0]    r_r, r_nxt;
  logic [23:0]    out_data_r;

  // memory
  logic [WORD_BITS-1:0] vis_mem [NW];
  logic [WORD_BITS-1:0] rd_data_r;
  logic                 rd_en, wr_en;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  // derived
  logic [CW-1:0]        n_eff;
  logic signed [12:0]   n_ext, nm1, pos_ext, prev_start, s_ext, rank_end;
  logic [PW-1:0]        s_nonneg, base, n_plus1, cnt_sum;
  logic [AW-1:0]        hi_word, lo_word;
  logic                 old_bit, new_bit;
  logic [CW-1:0]        pc_inc;
  logic [WORD_BITS-1:0] eval_word;
  wstat_t               ws;

  assign n_eff    = (cfg_r > CW'(MAXC)) ? CW'(MAXC) : cfg_r;
  assign n_ext    = $signed({2'b00, n_eff});
  assign nm1      = n_ext - 13'sd1;
  assign pos_ext  = $signed({pos_r[PW-1], pos_r});
  assign s_nonneg = pos_r[PW-1] ? '0 : pos_r;
  assign s_ext    = $signed({1'b0, s_nonneg});
  assign n_plus1  = PW'(n_eff) + PW'(1);
  assign base     = PW'({eval_addr_r, {WORD_LSB{1'b0}}});
  assign hi_word  = AW'(hi_r >> WORD_LSB);
  assign lo_word  = AW'(lo_r >> WORD_LSB);
  assign cnt_sum  = cnt_r + PW'(ws.ones);

  always_comb begin
    prev_start = pos_ext - 13'sd2;
    if (prev_start > nm1) begin
      prev_start = nm1;
    end
    rank_end = (s_ext > nm1) ? nm1 : s_ext;
  end

  assign eval_word = (state_r == S_BITS) ? word_r : rd_data_r;

  vbrs_word_eval u_word_eval (
    .word_i (eval_word),
    .base_i (base),
    .lo_i   (lo_r),
    .hi_i   (hi_r),
    .stat_o (ws)
  );

  assign old_bit = rd_data_r[pos_r[WORD_LSB-1:0]];
  assign new_bit = matched_r && (!narrow_r || old_bit);
  assign pc_inc  = (new_bit && (pc_r < COUNTER_MAX)) ? pc_r + CW'(1) : pc_r;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    total_nxt     = total_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    eval_addr_nxt = eval_addr_r;
    cnt_nxt       = cnt_r;
    ans_nxt       = ans_r;
    vis_nxt       = vis_r;
    word_nxt      = word_r;
    r_nxt         = r_r;
    out_valid_nxt = out_valid_r && !out_tready;
    rd_en         = 1'b0;
    rd_addr       = eval_addr_r;
    wr_en         = 1'b0;
    wr_addr       = eval_addr_r;
    wr_data       = rd_data_r;

    case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr_r;
        wr_data = '0;
        if (clr_addr_r == AW'(NW - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_START;
        end
      end

      S_START: begin
        vis_nxt   = 1'b0;
        ans_nxt   = '0;
        cnt_nxt   = '0;
        lo_nxt    = '0;
        state_nxt = S_EMIT;
        case (act_r)
          ACT_MARK: begin
            if (!pos_r[PW-1] && (pos_r[CW-1:0] < n_eff)) begin
              rd_en         = 1'b1;
              rd_addr       = AW'(pos_r >> WORD_LSB);
              eval_addr_nxt = rd_addr;
              state_nxt     = S_EVAL;
            end else if (last_r) begin
              total_nxt = pc_r;
              pc_nxt    = '0;
            end
          end
          ACT_NEXT: begin
            if (s_ext >= n_ext) begin
              ans_nxt = '1;
            end else begin
              lo_nxt        = s_nonneg;
              hi_nxt        = nm1[PW-1:0];
              rd_en         = 1'b1;
              rd_addr       = AW'(s_nonneg >> WORD_LSB);
              eval_addr_nxt = rd_addr;
              state_nxt     = S_EVAL;
            end
          end
          ACT_PREV: begin
            if (prev_start < 13'sd0) begin
              ans_nxt = '1;
            end else begin
              hi_nxt        = prev_start[PW-1:0];
              rd_en         = 1'b1;
              rd_addr       = AW'(prev_start[PW-1:0] >> WORD_LSB);
              eval_addr_nxt = rd_addr;
              state_nxt     = S_EVAL;
            end
          end
          ACT_RANK: begin
            if (total_r == '0) begin
              ans_nxt = pos_r;
            end else if (n_eff != '0) begin
              hi_nxt        = rank_end[PW-1:0];
              rd_en         = 1'b1;
              rd_addr       = '0;
              eval_addr_nxt = '0;
              state_nxt     = S_EVAL;
            end
          end
          ACT_SELECT: begin
            if ((n_eff == '0) || pos_r[PW-1]) begin
              ans_nxt = n_plus1;
            end else begin
              // k of zero only looks at entry zero
              hi_nxt        = (pos_r == '0) ? '0 : nm1[PW-1:0];
              rd_en         = 1'b1;
              rd_addr       = '0;
              eval_addr_nxt = '0;
              state_nxt     = S_EVAL;
            end
          end
          ACT_CLEAR: begin
            total_nxt = '0;
            pc_nxt    = '0;
          end
          default: begin
          end
        endcase
      end

      S_EVAL: begin
        state_nxt = S_EMIT;
        case (act_r)
          ACT_MARK: begin
            wr_en                          = 1'b1;
            wr_data[pos_r[WORD_LSB-1:0]]   = new_bit;
            vis_nxt                        = new_bit;
            if (last_r) begin
              total_nxt = pc_inc;
              pc_nxt    = '0;
            end else begin
              pc_nxt = pc_inc;
            end
          end
          ACT_NEXT: begin
            if (ws.any) begin
              ans_nxt = base + PW'(ws.lo_bit) + PW'(1);
            end else if (eval_addr_r == hi_word) begin
              ans_nxt = '1;
            end else begin
              rd_en         = 1'b1;
              rd_addr       = eval_addr_r + AW'(1);
              eval_addr_nxt = rd_addr;
              state_nxt     = S_EVAL;
            end
          end
          ACT_PREV: begin
            if (ws.any) begin
              ans_nxt = base + PW'(ws.hi_bit) + PW'(1);
            end else if (eval_addr_r == lo_word) begin
              ans_nxt = '1;
            end else begin
              rd_en         = 1'b1;
              rd_addr       = eval_addr_r - AW'(1);
              eval_addr_nxt = rd_addr;
              state_nxt     = S_EVAL;
            end
          end
          ACT_RANK: begin
            if (eval_addr_r == hi_word) begin
              ans_nxt = cnt_sum;
            end else begin
              cnt_nxt       = cnt_sum;
              rd_en         = 1'b1;
              rd_addr       = eval_addr_r + AW'(1);
              eval_addr_nxt = rd_addr;
              state_nxt     = S_EVAL;
            end
          end
          ACT_SELECT: begin
            if (pos_r == '0) begin
              ans_nxt = ws.masked[0] ? n_plus1 : '0;
            end else if (cnt_sum >= pos_r) begin
              // target lies in this word: hand over to the bit search
              word_nxt  = ws.masked;
              r_nxt     = ONES_W'(pos_r - cnt_r);
              state_nxt = S_BITS;
            end else if (eval_addr_r == hi_word) begin
              ans_nxt = n_plus1;
            end else begin
              cnt_nxt       = cnt_sum;
              rd_en         = 1'b1;
              rd_addr       = eval_addr_r + AW'(1);
              eval_addr_nxt = rd_addr;
              state_nxt     = S_EVAL;
            end
          end
          default: begin
          end
        endcase
      end

      S_BITS: begin
        if (r_r == ONES_W'(1)) begin
          ans_nxt   = base + PW'(ws.lo_bit);
          state_nxt = S_EMIT;
        end else begin
          // drop the lowest set bit and count it
          word_nxt            = word_r;
          word_nxt[ws.lo_bit] = 1'b0;
          r_nxt               = r_r - ONES_W'(1);
        end
      end

      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cfg_r       <= '0;
      pc_r        <= '0;
      total_r     <= '0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == S_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (cfg_wr_en) begin
        cfg_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      act_r     <= in_tuser;
      pos_r     <= in_tdata[11:0];
      matched_r <= in_tdata[12];
      narrow_r  <= in_tdata[13];
      last_r    <= in_tlast;
    end
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    eval_addr_r <= eval_addr_nxt;
    cnt_r       <= cnt_nxt;
    ans_r       <= ans_nxt;
    vis_r       <= vis_nxt;
    word_r      <= word_nxt;
    r_r         <= r_nxt;
    if ((state_r == S_EMIT) && (!out_valid_r || out_tready)) begin
      out_data_r <= {total_r, vis_r, ans_r};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      vis_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= vis_mem[rd_addr];
    end
  end

  `VBRS_ASSERT_IMP(a_wr_only_clear_or_mark, wr_en,
    (state_r == S_CLEAR) || ((state_r == S_EVAL) && (act_r == ACT_MARK)),
    "bitmap written outside clear pass or mark")
  `VBRS_ASSERT_IMP(a_bits_has_target, state_r == S_BITS,
    (word_r != '0) && (r_r != '0) && ($countones(word_r) >= r_r),
    "select bit search entered without a reachable target")
  `VBRS_ASSERT_NXT(a_accept_starts, in_tvalid && in_tready, state_r == S_START,
    "accepted word did not start processing")
  `VBRS_ASSERT_IMP(a_scan_in_window,
    (state_r == S_EVAL) && ((act_r == ACT_NEXT) || (act_r == ACT_PREV) ||
      (act_r == ACT_RANK) || (act_r == ACT_SELECT)),
    (eval_addr_r <= hi_word) && (eval_addr_r >= lo_word),
    "scan address left its window")

endmodule

`default_nettype wire

// File: rtl/vbrs_word_eval.sv
// ----------------------------------------------------------------------------
// vbrs_word_eval
// Masks one bitmap word to an index window and gives its population count
// and the positions of its lowest and highest set bits.
// ----------------------------------------------------------------------------
`default_nettype none

module vbrs_word_eval
  import vbrs_pkg::*;
(
  input  logic [WORD_BITS-1:0] word_i,
  input  logic [PW-1:0]        base_i,
  input  logic [PW-1:0]        lo_i,
  input  logic [PW-1:0]        hi_i,
  output wstat_t               stat_o
);

  always_comb begin
    logic [PW-1:0] idx;
    stat_o = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      idx = base_i + PW'(j);
      stat_o.masked[j] = word_i[j] && (idx >= lo_i) && (idx <= hi_i);
    end
    for (int j = 0; j < WORD_BITS; j++) begin
      stat_o.ones = stat_o.ones + ONES_W'(stat_o.masked[j]);
    end
    // lowest set bit wins: scan from the top down
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (stat_o.masked[j]) begin
        stat_o.lo_bit = WORD_LSB'(j);
      end
    end
    for (int j = 0; j < WORD_BITS; j++) begin
      if (stat_o.masked[j]) begin
        stat_o.hi_bit = WORD_LSB'(j);
      end
    end
    stat_o.any = |stat_o.masked;
  end

endmodule

`default_nettype wire
